>>> rtl/core/rse_pkg.sv
// Package for the randomized set engine: sizes, status and operation codes,
// and the word and control structs shared by the core modules.
// Depends on nothing.
package rse_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned VALUE_RANGE = 256;

  localparam int unsigned ValueW  = 8;
  localparam int unsigned RandW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = $clog2(CAPACITY + 1);
  localparam int unsigned SlotW   = $clog2(CAPACITY);
  localparam int unsigned MapW    = $clog2(VALUE_RANGE);
  localparam int unsigned StepW   = $clog2(RandW);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;

  localparam logic [StatusW-1:0] StatusOk      = 3'd0;
  localparam logic [StatusW-1:0] StatusEmpty   = 3'd1;
  localparam logic [StatusW-1:0] StatusAbsent  = 3'd2;
  localparam logic [StatusW-1:0] StatusFull    = 3'd3;
  localparam logic [StatusW-1:0] StatusPresent = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [ValueW-1:0] value;
    logic [RandW-1:0]  random_word;
  } in_word_t;

  typedef struct packed {
    logic [ValueW-1:0]  sampled_value;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic              elem_we;
    logic              elem_re;
    logic [SlotW-1:0]  elem_waddr;
    logic [SlotW-1:0]  elem_raddr;
    logic [ValueW-1:0] elem_wdata;
    logic              pos_we;
    logic              pos_re;
    logic [MapW-1:0]   pos_waddr;
    logic [MapW-1:0]   pos_raddr;
    logic [SlotW-1:0]  pos_wdata;
    logic              flag_we;
    logic              flag_wdata;
    logic [MapW-1:0]   flag_addr;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [RandW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] rem;
  } mod_rsp_t;

endpackage

>>> rtl/core/rse_store.sv
// Storage of the randomized set engine: element store and position map as
// synchronous RAMs with registered reads, plus the membership flags.
// Depends on rse_pkg.
module rse_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rse_pkg::mem_req_t         req_i,
  output logic [rse_pkg::ValueW-1:0] elem_rdata_o,
  output logic [rse_pkg::SlotW-1:0]  pos_rdata_o,
  output logic                      flag_o
);
  import rse_pkg::*;

  logic [ValueW-1:0]      elem_mem [CAPACITY];
  logic [SlotW-1:0]       pos_mem  [VALUE_RANGE];
  logic [ValueW-1:0]      elem_rdata_q;
  logic [SlotW-1:0]       pos_rdata_q;
  logic [VALUE_RANGE-1:0] flags_q;
  logic [VALUE_RANGE-1:0] flags_d;

  always_ff @(posedge clk_i) begin
    if (req_i.elem_we) begin
      elem_mem[req_i.elem_waddr] <= req_i.elem_wdata;
    end
    if (req_i.elem_re) begin
      elem_rdata_q <= elem_mem[req_i.elem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pos_we) begin
      pos_mem[req_i.pos_waddr] <= req_i.pos_wdata;
    end
    if (req_i.pos_re) begin
      pos_rdata_q <= pos_mem[req_i.pos_raddr];
    end
  end

  always_comb begin
    flags_d = flags_q;
    if (req_i.flag_we) begin
      flags_d[req_i.flag_addr] = req_i.flag_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign elem_rdata_o = elem_rdata_q;
  assign pos_rdata_o  = pos_rdata_q;
  assign flag_o       = flags_q[req_i.flag_addr];

endmodule

>>> rtl/core/rse_mod.sv
// Iterative remainder unit of the randomized set engine: one restoring
// step per cycle over the random word, divided by the running count.
// Depends on rse_pkg.
module rse_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rse_pkg::mod_req_t req_i,
  output rse_pkg::mod_rsp_t rsp_o
);
  import rse_pkg::*;

  logic [RandW-1:0]  dvd_q, dvd_d;
  logic [CountW-1:0] div_q, div_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CountW:0]   shifted;
  logic [CountW:0]   diff;

  assign shifted = {rem_q, dvd_q[RandW-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[CountW-1:0];
      end else begin
        rem_d = shifted[CountW-1:0];
      end
      dvd_d  = {dvd_q[RandW-2:0], 1'b0};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(RandW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/core/randomized_set_engine.sv
// Randomized set engine: insert, remove and uniform sampling over a set of
// 8-bit values. Insert and any refused word end in the execute state, remove
// adds a RAM read, sample runs one remainder step per bit of the random
// word, then a RAM read. One word at a time; busy_o is high until the result
// strobe, so the next word can be accepted at the edge that takes the result.
// The receiver cannot stall. Reset clears the membership flags and the count.
module randomized_set_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rse_pkg::in_word_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output rse_pkg::out_word_t rsp_o
);
  import rse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MOD  = 4'b0100,
    S_READ = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              done_q, done_d;
  out_word_t         res_q, res_d;
  in_word_t          word_q;
  mem_req_t          mem_req;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  logic [ValueW-1:0] elem_rdata;
  logic [SlotW-1:0]  pos_rdata;
  logic              flag;
  logic              accept;
  logic              val_out;
  logic [CountW-1:0] count_m1;

  assign accept   = start_i && (state_q == S_IDLE);
  assign val_out  = 32'(word_q.value) >= VALUE_RANGE;
  assign count_m1 = count_q - CountW'(1);

  rse_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .elem_rdata_o(elem_rdata),
    .pos_rdata_o (pos_rdata),
    .flag_o      (flag)
  );

  rse_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  always_comb begin
    state_d           = state_q;
    count_d           = count_q;
    done_d            = 1'b0;
    res_d             = res_q;
    mem_req           = '0;
    mem_req.flag_addr = word_q.value[MapW-1:0];
    mod_req.start     = 1'b0;
    mod_req.dividend  = word_q.random_word;
    mod_req.divisor   = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d.sampled_value = '0;
        res_d.status        = StatusOk;
        done_d              = 1'b1;
        state_d             = S_IDLE;
        unique case (word_q.op)
          OpInsert: begin
            priority if (val_out) begin
              res_d.status = StatusAbsent;
            end else if (flag) begin
              res_d.status = StatusPresent;
            end else if (count_q == CountW'(CAPACITY)) begin
              res_d.status = StatusFull;
            end else begin
              mem_req.elem_we    = 1'b1;
              mem_req.elem_waddr = count_q[SlotW-1:0];
              mem_req.elem_wdata = word_q.value;
              mem_req.pos_we     = 1'b1;
              mem_req.pos_waddr  = word_q.value[MapW-1:0];
              mem_req.pos_wdata  = count_q[SlotW-1:0];
              mem_req.flag_we    = 1'b1;
              mem_req.flag_wdata = 1'b1;
              count_d            = count_q + CountW'(1);
            end
          end
          OpRemove: begin
            priority if (count_q == '0) begin
              res_d.status = StatusEmpty;
            end else if (val_out || !flag) begin
              res_d.status = StatusAbsent;
            end else begin
              mem_req.elem_re    = 1'b1;
              mem_req.elem_raddr = count_m1[SlotW-1:0];
              mem_req.pos_re     = 1'b1;
              mem_req.pos_raddr  = word_q.value[MapW-1:0];
              done_d             = 1'b0;
              state_d            = S_READ;
            end
          end
          OpSample: begin
            if (count_q == '0) begin
              res_d.status = StatusEmpty;
            end else begin
              mod_req.start = 1'b1;
              done_d        = 1'b0;
              state_d       = S_MOD;
            end
          end
          default: begin
            res_d.status = StatusOk;
          end
        endcase
        res_d.count = count_d;
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          mem_req.elem_re    = 1'b1;
          mem_req.elem_raddr = mod_rsp.rem[SlotW-1:0];
          state_d            = S_READ;
        end
      end
      S_READ: begin
        res_d.status        = StatusOk;
        res_d.sampled_value = '0;
        if (word_q.op == OpRemove) begin
          mem_req.elem_we    = 1'b1;
          mem_req.elem_waddr = pos_rdata;
          mem_req.elem_wdata = elem_rdata;
          mem_req.pos_we     = 1'b1;
          mem_req.pos_waddr  = elem_rdata[MapW-1:0];
          mem_req.pos_wdata  = pos_rdata;
          mem_req.flag_we    = 1'b1;
          mem_req.flag_wdata = 1'b0;
          count_d            = count_m1;
        end else begin
          res_d.sampled_value = elem_rdata;
        end
        res_d.count = count_d;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      word_q <= req_i;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = res_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while an operation is in flight");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result strobes in a row");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("element count beyond capacity");

endmodule
